>>> design/psrms_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the phase synchronized RMS meter.
// No dependencies; every other design file imports this package.
package psrms_pkg;

  localparam int SampleWidthDef = 16;
  localparam int CountWidthDef  = 10;
  localparam int PhaseWidth     = 16;
  localparam int RmsWidth       = 16;
  localparam int CoefWidth      = 16;
  localparam int ThreshWidth    = 16;
  localparam int TimeoutWidth   = 10;
  localparam int CfgAddrWidth   = 2;
  localparam int CfgDataWidth   = 16;
  localparam int FifoDepth      = 2;
  localparam int CoefOne        = 32768;

  localparam logic [ThreshWidth-1:0]  WrapThreshRst = 16'd32768;
  localparam logic [CoefWidth-1:0]    CoefRst       = 16'd32768;
  localparam logic [TimeoutWidth-1:0] TimeoutRst    = 10'd100;

  typedef enum logic [CfgAddrWidth-1:0] {
    CFG_WRAP_THRESHOLD = 2'd0,
    CFG_SMOOTHING_COEF = 2'd1,
    CFG_TIMEOUT_COUNT  = 2'd2
  } psrms_cfg_addr_e;

  typedef struct packed {
    logic [ThreshWidth-1:0]  wrap_threshold;
    logic [CoefWidth-1:0]    smoothing_coef;
    logic [TimeoutWidth-1:0] timeout_count;
  } psrms_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_BLEND
  } psrms_state_e;

  typedef struct packed {
    logic busy;
    logic start;
  } psrms_bstat_t;

endpackage

>>> design/psrms_front.sv
`timescale 1ns / 1ps
// Front end: accepts samples, squares the magnitude and flags a phase wrap.
// Depends on psrms_pkg.
module psrms_front #(
  parameter int SAMPLE_WIDTH = psrms_pkg::SampleWidthDef,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [psrms_pkg::ThreshWidth-1:0]    wrap_threshold_i,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  input  logic [DATA_WIDTH-1:0]                s_axis_tdata_i,
  input  logic                                 q_full_i,
  output logic                                 q_push_o,
  output logic [2*SAMPLE_WIDTH-1:0]            q_wdata_o
);
  import psrms_pkg::*;

  localparam int SqWidth = 2 * SAMPLE_WIDTH - 1;

  logic [SAMPLE_WIDTH-1:0]   sample;
  logic [PhaseWidth-1:0]     phase;
  logic [SAMPLE_WIDTH-1:0]   mag;
  logic [2*SAMPLE_WIDTH-1:0] sq_full;
  logic [PhaseWidth-1:0]     jump;
  logic                      wrap;
  logic [PhaseWidth-1:0]     prev_phase_q, prev_phase_d;

  assign sample  = s_axis_tdata_i[SAMPLE_WIDTH-1:0];
  assign phase   = s_axis_tdata_i[SAMPLE_WIDTH +: PhaseWidth];
  assign mag     = sample[SAMPLE_WIDTH-1] ? (~sample + 1'b1) : sample;
  assign sq_full = mag * mag;
  assign jump    = (phase > prev_phase_q) ? (phase - prev_phase_q) : (prev_phase_q - phase);
  assign wrap    = jump > wrap_threshold_i;

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;
  assign q_wdata_o       = {sq_full[SqWidth-1:0], wrap};

  always_comb begin
    prev_phase_d = prev_phase_q;
    if (q_push_o) begin
      prev_phase_d = phase;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_phase_q <= '0;
    end else begin
      prev_phase_q <= prev_phase_d;
    end
  end

endmodule

>>> design/psrms_fifo.sv
`timescale 1ns / 1ps
// Short register queue between the front end and the back end.
// Depends on psrms_pkg.
module psrms_fifo #(
  parameter int WIDTH = 32,
  parameter int DEPTH = psrms_pkg::FifoDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);
  import psrms_pkg::*;

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [AddrW:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == (AddrW + 1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> design/psrms_back.sv
`timescale 1ns / 1ps
// Back end: accumulates squares, runs the bit-serial divide and square root,
// blends the cycle RMS and drives the output register. Depends on psrms_pkg.
module psrms_back #(
  parameter int SAMPLE_WIDTH = psrms_pkg::SampleWidthDef,
  parameter int COUNT_WIDTH  = psrms_pkg::CountWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  psrms_pkg::psrms_cfg_t             cfg_i,
  input  logic                              q_empty_i,
  input  logic [2*SAMPLE_WIDTH-1:0]         q_rdata_i,
  output logic                              q_pop_o,
  output psrms_pkg::psrms_bstat_t           bstat_o,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [psrms_pkg::RmsWidth-1:0]    m_axis_tdata_o,
  output logic                              m_axis_tuser_o
);
  import psrms_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int CW    = COUNT_WIDTH;
  localparam int SqW   = 2 * SW - 1;
  localparam int SumW  = SqW + CW;
  localparam int RadW  = 2 * SW;
  localparam int RemW  = SW + 2;
  localparam int PaW   = SW + CoefWidth;
  localparam int PbW   = RmsWidth + CoefWidth;
  localparam int BlW   = ((PaW > PbW) ? PaW : PbW) + 1;
  localparam int StepW = $clog2(SumW + 1);

  psrms_state_e          state_q, state_d;
  logic [StepW-1:0]      step_q, step_d;
  logic [SumW-1:0]       sum_q, sum_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [RmsWidth-1:0]   rms_q, rms_d;
  logic [SumW-1:0]       quo_q, quo_d;
  logic [CW-1:0]         drem_q, drem_d;
  logic [CW-1:0]         div_q, div_d;
  logic [RadW-1:0]       rad_q, rad_d;
  logic [SW-1:0]         root_q, root_d;
  logic [RemW-1:0]       srem_q, srem_d;
  logic [PaW-1:0]        pa_q, pa_d;
  logic [PbW-1:0]        pb_q, pb_d;
  logic                  m_valid_q, m_valid_d;
  logic [RmsWidth-1:0]   m_rms_q, m_rms_d;
  logic                  m_upd_q, m_upd_d;

  logic                  can_emit;
  logic [SqW-1:0]        q_sq;
  logic                  q_wrap;
  logic [SumW-1:0]       sum_add;
  logic [CW-1:0]         cnt_inc;
  logic                  timeout_hit;
  logic [CW:0]           dtrial, ddiff;
  logic                  dge;
  logic [RemW-1:0]       strial, sshift;
  logic                  sge;
  logic [CoefWidth-1:0]  c_sat, c_inv;
  logic [BlW-1:0]        bsum;
  logic [RmsWidth-1:0]   new_rms;

  assign can_emit    = !m_valid_q || m_axis_tready_i;
  assign q_sq        = q_rdata_i[2*SW-1:1];
  assign q_wrap      = q_rdata_i[0];
  assign sum_add     = sum_q + SumW'(q_sq);
  assign cnt_inc     = cnt_q + 1'b1;
  assign timeout_hit = (32'(cnt_inc) >= 32'(cfg_i.timeout_count)) || (cnt_inc == '1);

  assign dtrial = {drem_q, quo_q[SumW-1]};
  assign dge    = dtrial >= {1'b0, div_q};
  assign ddiff  = dtrial - {1'b0, div_q};

  assign sshift = {srem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign strial = {root_q, 2'b01};
  assign sge    = sshift >= strial;

  assign c_sat   = (cfg_i.smoothing_coef > CoefWidth'(CoefOne)) ? CoefWidth'(CoefOne)
                                                                : cfg_i.smoothing_coef;
  assign c_inv   = CoefWidth'(CoefOne) - c_sat;
  assign bsum    = BlW'(pa_q) + BlW'(pb_q);
  assign new_rms = bsum[15 +: RmsWidth];

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_rms_q;
  assign m_axis_tuser_o  = m_upd_q;
  assign bstat_o.busy    = state_q != ST_IDLE;
  assign bstat_o.start   = q_pop_o && q_wrap;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    rms_d     = rms_q;
    quo_d     = quo_q;
    drem_d    = drem_q;
    div_d     = div_q;
    rad_d     = rad_q;
    root_d    = root_q;
    srem_d    = srem_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_rms_d   = m_rms_q;
    m_upd_d   = m_upd_q;
    q_pop_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i && can_emit) begin
          q_pop_o = 1'b1;
          if (q_wrap) begin
            quo_d   = sum_add;
            div_d   = cnt_inc;
            drem_d  = '0;
            step_d  = '0;
            sum_d   = '0;
            cnt_d   = '0;
            state_d = ST_DIV;
          end else if (timeout_hit) begin
            sum_d     = '0;
            cnt_d     = '0;
            rms_d     = '0;
            m_valid_d = 1'b1;
            m_rms_d   = '0;
            m_upd_d   = 1'b1;
          end else begin
            sum_d     = sum_add;
            cnt_d     = cnt_inc;
            m_valid_d = 1'b1;
            m_rms_d   = rms_q;
            m_upd_d   = 1'b0;
          end
        end
      end
      ST_DIV: begin
        drem_d = dge ? ddiff[CW-1:0] : dtrial[CW-1:0];
        quo_d  = {quo_q[SumW-2:0], dge};
        if (step_q == StepW'(SumW - 1)) begin
          rad_d   = {1'b0, quo_d[SqW-1:0]};
          srem_d  = '0;
          root_d  = '0;
          step_d  = '0;
          state_d = ST_SQRT;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_SQRT: begin
        srem_d = sge ? (sshift - strial) : sshift;
        root_d = {root_q[SW-2:0], sge};
        rad_d  = rad_q << 2;
        if (step_q == StepW'(SW - 1)) begin
          state_d = ST_MUL;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_MUL: begin
        pa_d    = PaW'(root_q) * PaW'(c_sat);
        pb_d    = PbW'(rms_q) * PbW'(c_inv);
        state_d = ST_BLEND;
      end
      ST_BLEND: begin
        if (can_emit) begin
          rms_d     = new_rms;
          m_valid_d = 1'b1;
          m_rms_d   = new_rms;
          m_upd_d   = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      rms_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      step_q    <= step_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      rms_q     <= rms_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    drem_q  <= drem_d;
    div_q   <= div_d;
    rad_q   <= rad_d;
    root_q  <= root_d;
    srem_q  <= srem_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    m_rms_q <= m_rms_d;
    m_upd_q <= m_upd_d;
  end

endmodule

>>> design/phase_synced_rms_meter_core.sv
`timescale 1ns / 1ps
// Top level of the phase synchronized RMS meter: configuration registers,
// front end, queue and back end. Depends on psrms_pkg and all psrms modules.
//
// One result per sample. A sample that does not end a phase cycle is queued and
// its result goes to the output register once the output is free; the block
// takes one such sample per cycle while the output is ready. A sample whose
// phase jump exceeds the wrap threshold starts the cycle computation: the back
// end takes it from the queue, then a restoring divider produces one quotient
// bit per cycle, a square root produces one root bit per cycle, and a multiply
// step and a blend step follow. The two-entry queue takes up to two more
// samples meanwhile; then the input stalls until the blended result is issued.
// Configuration writes are always ready and should be issued while idle.
module phase_synced_rms_meter_core #(
  parameter int SAMPLE_WIDTH = psrms_pkg::SampleWidthDef,
  parameter int COUNT_WIDTH  = psrms_pkg::CountWidthDef
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // sample [SAMPLE_WIDTH-1:0], phase [+16], zero padding to whole bytes
  input  logic [((SAMPLE_WIDTH + psrms_pkg::PhaseWidth + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // rms_value [15:0]
  output logic [psrms_pkg::RmsWidth-1:0]        m_axis_tdata,
  // updated [0]
  output logic                                  m_axis_tuser,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [psrms_pkg::CfgAddrWidth-1:0]    cfg_addr_i,
  input  logic [psrms_pkg::CfgDataWidth-1:0]    cfg_data_i
);
  import psrms_pkg::*;

  localparam int InDataW = ((SAMPLE_WIDTH + PhaseWidth + 7) / 8) * 8;
  localparam int QW      = 2 * SAMPLE_WIDTH;

  psrms_cfg_t   cfg_q, cfg_d;
  psrms_bstat_t bstat;
  logic         fifo_push, fifo_pop, fifo_full, fifo_empty;
  logic [QW-1:0] fifo_wdata, fifo_rdata;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (psrms_cfg_addr_e'(cfg_addr_i))
        CFG_WRAP_THRESHOLD: cfg_d.wrap_threshold = cfg_data_i[ThreshWidth-1:0];
        CFG_SMOOTHING_COEF: cfg_d.smoothing_coef = cfg_data_i[CoefWidth-1:0];
        CFG_TIMEOUT_COUNT:  cfg_d.timeout_count  = cfg_data_i[TimeoutWidth-1:0];
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wrap_threshold <= WrapThreshRst;
      cfg_q.smoothing_coef <= CoefRst;
      cfg_q.timeout_count  <= TimeoutRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  psrms_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .DATA_WIDTH   (InDataW)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .wrap_threshold_i (cfg_q.wrap_threshold),
    .s_axis_tvalid_i  (s_axis_tvalid),
    .s_axis_tready_o  (s_axis_tready),
    .s_axis_tdata_i   (s_axis_tdata),
    .q_full_i         (fifo_full),
    .q_push_o         (fifo_push),
    .q_wdata_o        (fifo_wdata)
  );

  psrms_fifo #(
    .WIDTH (QW),
    .DEPTH (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (fifo_wdata),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .empty_o (fifo_empty),
    .rdata_o (fifo_rdata)
  );

  psrms_back #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_empty_i       (fifo_empty),
    .q_rdata_i       (fifo_rdata),
    .q_pop_o         (fifo_pop),
    .bstat_o         (bstat),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  a_no_pop_while_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.busy |-> !fifo_pop)
    else $error("queue popped during cycle computation");

  a_start_clears_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.start |=> bstat.busy && !m_axis_tvalid)
    else $error("cycle computation did not start cleanly");

  a_busy_ends_with_update : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(bstat.busy) |-> m_axis_tvalid && m_axis_tuser)
    else $error("cycle computation ended without an updated result");

endmodule

>>> bench/phase_synced_rms_meter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for phase_synced_rms_meter_core: directed table, then random
// phase ramps and noise, each result checked by table or in-bench RMS predictor.
// Depends on psrms_pkg and the design files only.
module phase_synced_rms_meter_core_tb;
  import psrms_pkg::*;

  localparam int          ClkHalf     = 5;
  localparam int          CycleLimit  = 1000000;
  localparam int          DrainCycles = 80;
  localparam int          RandPhases  = 8;
  localparam int          PhaseItems  = 85;
  localparam int          CountMax    = (1 << CountWidthDef) - 1;
  localparam logic [1:0]  CfgAddrSpare = 2'd3;

  typedef enum logic { ROW_SAMPLE, ROW_WRITE } row_kind_e;

  typedef struct packed {
    logic [15:0] rms;
    logic        upd;
  } meter_out_t;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  addr;
    logic [15:0] val;
    logic [15:0] ph;
    logic        typed;
    meter_out_t  res;
  } plan_row_t;

  localparam int PlanLen = 28;
  localparam plan_row_t DirectedPlan [PlanLen] = '{
    '{ROW_SAMPLE, 2'd0, 16'h0000, 16'd0,     1'b1, '{16'd0,     1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'h8000, 16'd16384, 1'b1, '{16'd0,     1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'h8000, 16'd49152, 1'b1, '{16'd0,     1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'h8000, 16'd0,     1'b0, '{16'd0,     1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'h7FFF, 16'd65535, 1'b1, '{16'd32767, 1'b1}},
    '{ROW_SAMPLE, 2'd0, 16'h8000, 16'd0,     1'b1, '{16'd32768, 1'b1}},
    '{ROW_SAMPLE, 2'd0, 16'h0001, 16'd1,     1'b1, '{16'd32768, 1'b0}},
    '{ROW_WRITE,  CFG_WRAP_THRESHOLD, 16'h0000, 16'd0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_WRITE,  CFG_SMOOTHING_COEF, 16'hFFFF, 16'd0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'hFFFF, 16'd2,     1'b1, '{16'd1,     1'b1}},
    '{ROW_SAMPLE, 2'd0, 16'h0005, 16'd2,     1'b1, '{16'd1,     1'b0}},
    '{ROW_WRITE,  CFG_TIMEOUT_COUNT,  16'hFC00, 16'd0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'h0007, 16'd2,     1'b1, '{16'd0,     1'b1}},
    '{ROW_WRITE,  CFG_TIMEOUT_COUNT,  16'h0001, 16'd0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'h0003, 16'd2,     1'b1, '{16'd0,     1'b1}},
    '{ROW_WRITE,  CfgAddrSpare,       16'hFFFF, 16'd0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_WRITE,  CFG_SMOOTHING_COEF, 16'h0000, 16'd0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_WRITE,  CFG_TIMEOUT_COUNT,  16'hFFFF, 16'd0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_WRITE,  CFG_WRAP_THRESHOLD, 16'hFFFF, 16'd0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'h7FFF, 16'd65535, 1'b1, '{16'd0,     1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'h8000, 16'd0,     1'b1, '{16'd0,     1'b0}},
    '{ROW_WRITE,  CFG_WRAP_THRESHOLD, 16'd100,   16'd0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_WRITE,  CFG_SMOOTHING_COEF, 16'd16384, 16'd0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'h8000, 16'd32768, 1'b0, '{16'd0,     1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'h0000, 16'd32768, 1'b0, '{16'd0,     1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'd12345, 16'd0,    1'b0, '{16'd0,     1'b0}},
    '{ROW_WRITE,  CFG_SMOOTHING_COEF, 16'h0000, 16'd0, 1'b0, '{16'd0, 1'b0}},
    '{ROW_SAMPLE, 2'd0, 16'd100,  16'd40000, 1'b0, '{16'd0,     1'b0}}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i;
  logic [15:0] cfg_data_i;

  // meter state as the predictor sees it
  logic [15:0]     mdl_thresh;
  logic [15:0]     mdl_coef;
  logic [9:0]      mdl_timeout;
  logic [15:0]     mdl_prev_phase;
  longint unsigned mdl_sum;
  longint unsigned mdl_count;
  logic [15:0]     mdl_rms;

  meter_out_t expected_rms_q [$];
  meter_out_t got_res;
  int         mismatch_cnt;
  int         cycle_cnt;
  int         src_idle_pct;
  int         snk_stall_pct;

  phase_synced_rms_meter_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #ClkHalf clk_i = ~clk_i;

  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic meter_out_t predict_meter(input logic [15:0] smp, input logic [15:0] ph);
    int              sv;
    longint unsigned mag;
    longint unsigned root;
    longint unsigned c;
    longint unsigned blend;
    int unsigned     jump;
    meter_out_t      res;
    sv = int'($signed(smp));
    mag = (sv < 0) ? longint'(-sv) : longint'(sv);
    jump = (ph > mdl_prev_phase) ? 32'(ph) - 32'(mdl_prev_phase)
                                 : 32'(mdl_prev_phase) - 32'(ph);
    mdl_sum += mag * mag;
    mdl_count += 1;
    res.upd = 1'b0;
    if (jump > 32'(mdl_thresh)) begin
      root = floor_sqrt(mdl_sum / mdl_count);
      c = (mdl_coef > CoefOne) ? CoefOne : longint'(mdl_coef);
      blend = (root * c + longint'(mdl_rms) * (CoefOne - c)) >> 15;
      mdl_rms = blend[15:0];
      mdl_sum = 0;
      mdl_count = 0;
      res.upd = 1'b1;
    end else if (mdl_count >= mdl_timeout || mdl_count >= CountMax) begin
      mdl_sum = 0;
      mdl_count = 0;
      mdl_rms = '0;
      res.upd = 1'b1;
    end
    mdl_prev_phase = ph;
    res.rms = mdl_rms;
    return res;
  endfunction

  task automatic write_reg(input logic [1:0] addr, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (addr)
      CFG_WRAP_THRESHOLD: mdl_thresh  = data;
      CFG_SMOOTHING_COEF: mdl_coef    = data;
      CFG_TIMEOUT_COUNT:  mdl_timeout = data[TimeoutWidth-1:0];
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [15:0] smp, input logic [15:0] ph,
                             input logic typed, input meter_out_t typed_res);
    meter_out_t res;
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ph, smp};
    res = predict_meter(smp, ph);
    expected_rms_q.push_back(typed ? typed_res : res);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_rms_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
      1: begin src_idle_pct = 77; snk_stall_pct = 0;  end
      2: begin src_idle_pct = 0;  snk_stall_pct = 77; end
      default: begin src_idle_pct = 24; snk_stall_pct = 24; end
    endcase
  endtask

  task automatic randomize_config();
    logic [15:0] thr;
    logic [15:0] coef;
    logic [15:0] tmo;
    case ($urandom_range(3))
      0: thr = 16'($urandom_range(65535));
      1: thr = 16'($urandom_range(36864, 28672));
      2: thr = 16'($urandom_range(2000));
      default: thr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    endcase
    case ($urandom_range(3))
      0: coef = 16'($urandom_range(32768));
      1: coef = 16'(CoefOne);
      2: coef = 16'h0000;
      default: coef = 16'($urandom_range(65535));
    endcase
    case ($urandom_range(3))
      0: tmo = 16'($urandom_range(65535));
      1: tmo = 16'($urandom_range(3));
      default: tmo = 16'($urandom_range(150, 2));
    endcase
    if ($urandom_range(2) == 0) write_reg(CfgAddrSpare, 16'($urandom_range(65535)));
    if ($urandom_range(1)) begin
      write_reg(CFG_TIMEOUT_COUNT, tmo);
      write_reg(CFG_WRAP_THRESHOLD, thr);
      write_reg(CFG_SMOOTHING_COEF, coef);
    end else begin
      write_reg(CFG_SMOOTHING_COEF, coef);
      write_reg(CFG_WRAP_THRESHOLD, thr);
      write_reg(CFG_TIMEOUT_COUNT, tmo);
    end
  endtask

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_rms_q.size() == 0) begin
        $display("%0t: unexpected transfer, expected none, actual rms=%0d updated=%0b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatch_cnt++;
      end else begin
        got_res = expected_rms_q.pop_front();
        if (m_axis_tdata !== got_res.rms) begin
          $display("%0t: rms_value mismatch, expected %0d, actual %0d",
                   $time, got_res.rms, m_axis_tdata);
          mismatch_cnt++;
        end
        if (m_axis_tuser !== got_res.upd) begin
          $display("%0t: updated mismatch, expected %0b, actual %0b",
                   $time, got_res.upd, m_axis_tuser);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) @(posedge clk_i);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic        prev_item;
    logic [15:0] smp;
    int          ph_acc;
    int          sent;
    int          n;
    int          amp;
    int          step;
    int          sv;
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_addr_i    = '0;
    cfg_data_i    = '0;
    mismatch_cnt  = 0;
    cycle_cnt     = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    mdl_thresh     = WrapThreshRst;
    mdl_coef       = CoefRst;
    mdl_timeout    = TimeoutRst;
    mdl_prev_phase = '0;
    mdl_sum        = 0;
    mdl_count      = 0;
    mdl_rms        = '0;
    ph_acc         = 0;
    prev_item      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(3);
    for (int i = 0; i < PlanLen; i++) begin
      if (DirectedPlan[i].kind == ROW_WRITE) begin
        if (prev_item) settle();
        write_reg(DirectedPlan[i].addr, DirectedPlan[i].val);
        prev_item = 1'b0;
      end else begin
        send_sample(DirectedPlan[i].val, DirectedPlan[i].ph,
                    DirectedPlan[i].typed, DirectedPlan[i].res);
        prev_item = 1'b1;
      end
    end

    for (int p = 0; p < RandPhases; p++) begin
      settle();
      randomize_config();
      set_idling(p % 4);
      sent = 0;
      while (sent < PhaseItems) begin
        if ($urandom_range(9) < 8) begin
          // one ramp period with random amplitude
          n    = $urandom_range(160, 2);
          amp  = $urandom_range(32768, 1);
          step = 65536 / n;
          for (int k = 0; k < n; k++) begin
            sv = int'($urandom_range(2 * amp)) - amp;
            if (sv > 32767) sv = 32767;
            ph_acc = (ph_acc + step + int'($urandom_range(16)) - 8) & 32'hFFFF;
            smp = sv[15:0];
            send_sample(smp, ph_acc[15:0], 1'b0, '0);
          end
          sent += n;
        end else begin
          n = $urandom_range(8, 1);
          for (int k = 0; k < n; k++) begin
            send_sample(16'($urandom_range(65535)), 16'($urandom_range(65535)), 1'b0, '0);
          end
          sent += n;
        end
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> phase_synced_rms_meter_core.f
design/psrms_pkg.sv
design/psrms_front.sv
design/psrms_fifo.sv
design/psrms_back.sv
design/phase_synced_rms_meter_core.sv
bench/phase_synced_rms_meter_core_tb.sv
